### hw/rtl/glu_pkg.sv
// glu_pkg: shared types and constants for the gcd/lcm unit.
// Request and result payloads, controller command and status groups.
// No dependencies.
package glu_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int OPERAND_W      = 32;
    localparam int DIVISOR_W      = 32;
    localparam int MULTIPLE_W     = 63;

    typedef struct packed {
        logic signed [OPERAND_W-1:0] operand_a;
        logic signed [OPERAND_W-1:0] operand_b;
    } glu_req_t;

    typedef struct packed {
        logic [DIVISOR_W-1:0]  divisor;
        logic [MULTIPLE_W-1:0] multiple;
        logic                  zero_divide;
    } glu_rsp_t;

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic gcd_latch;
        logic div_step;
        logic mul;
    } glu_cmd_t;

    typedef struct packed {
        logic gcd_zero;
        logic div_last;
    } glu_stat_t;

endpackage

### hw/rtl/gcd_lcm_unit.sv
// gcd_lcm_unit: greatest common divisor and least common multiple of two
// signed operands. Top level; depends on glu_pkg, glu_ctrl, glu_datapath.
//
// Usage:
//   Drive request and raise start; the request is taken at a rising edge
//   with start high and busy low. busy stays high until the result is out.
//   The result appears on result, marked by done for exactly one cycle,
//   and is taken at the edge that ends that cycle; the receiver cannot
//   stall it, so capture it while done is high. done and busy are never
//   high together, so a new request may be issued in the done cycle.
//   Operands use their low DATA_WIDTH bits, sign-extended from the top one.
// Sequencing:
//   One item at a time. After accept the unit runs binary gcd steps
//   (one shift or one subtract-and-shift per cycle), followed by a
//   one-bit-per-cycle divider and one multiply.
// Reset:
//   rst_n clears the controller to idle and drops done; a request in
//   flight is abandoned.
module gcd_lcm_unit #(
    parameter int DATA_WIDTH = glu_pkg::DATA_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  glu_pkg::glu_req_t   request,
    output logic                done,
    output glu_pkg::glu_rsp_t   result
);
    import glu_pkg::*;

    glu_cmd_t  cmd;
    glu_stat_t stat;

    glu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    glu_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

endmodule

### hw/rtl/glu_ctrl.sv
// glu_ctrl: sequencing state machine for the gcd/lcm unit.
// Issues datapath commands from its status; depends on glu_pkg.
module glu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  glu_pkg::glu_stat_t   stat,
    output glu_pkg::glu_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);
    import glu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_GCD  = 4'b0010,
        S_DIV  = 4'b0100,
        S_MUL  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (stat.gcd_zero)
                begin
                    cmd.gcd_latch = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done_next = (state_reg == S_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

`ifndef ASSERT_OFF
    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start work");

    a_single_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.gcd_step, cmd.gcd_latch, cmd.div_step, cmd.mul}))
        else $error("more than one datapath command");
`endif

endmodule

### hw/rtl/glu_datapath.sv
// glu_datapath: operand registers, binary gcd stepper, bit-serial divider,
// multiplier and result register for the gcd/lcm unit. Depends on glu_pkg.
module glu_datapath #(
    parameter int DATA_WIDTH = glu_pkg::DATA_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  glu_pkg::glu_req_t    request,
    input  glu_pkg::glu_cmd_t    cmd,
    output glu_pkg::glu_stat_t   stat,
    output glu_pkg::glu_rsp_t    result
);
    import glu_pkg::*;

    localparam int W      = DATA_WIDTH;
    localparam int CNT_W  = $clog2(DATA_WIDTH);
    localparam int PROD_W = 2 * DATA_WIDTH;

    logic [W-1:0]      opnd_a;
    logic [W-1:0]      opnd_b;
    logic [W-1:0]      mag_a;
    logic [W-1:0]      mag_b;
    logic [W:0]        diff_xy;
    logic [W:0]        diff_yx;
    logic [W:0]        shift_rem;
    logic [W:0]        trial;
    logic [PROD_W-1:0] prod;

    logic [W-1:0]     ma_reg, ma_next;
    logic [W-1:0]     mb_reg, mb_next;
    logic [W-1:0]     x_reg, x_next;
    logic [W-1:0]     y_reg, y_next;
    logic [W-1:0]     g_reg, g_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    glu_rsp_t         result_reg, result_next;

    assign opnd_a = request.operand_a[W-1:0];
    assign opnd_b = request.operand_b[W-1:0];
    assign mag_a  = opnd_a[W-1] ? (~opnd_a + 1'b1) : opnd_a;
    assign mag_b  = opnd_b[W-1] ? (~opnd_b + 1'b1) : opnd_b;

    assign diff_xy   = {1'b0, x_reg} - {1'b0, y_reg};
    assign diff_yx   = {1'b0, y_reg} - {1'b0, x_reg};
    assign shift_rem = {rem_reg, quo_reg[W-1]};
    assign trial     = shift_rem - {1'b0, g_reg};
    assign prod      = PROD_W'(quo_reg) * PROD_W'(mb_reg);

    always_comb
    begin
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        k_next      = k_reg;
        g_next      = g_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;

        if (cmd.load)
        begin
            ma_next = mag_a;
            mb_next = mag_b;
            x_next  = mag_a;
            y_next  = mag_b;
            k_next  = '0;
        end

        if (cmd.gcd_step)
        begin
            if (!x_reg[0] && !y_reg[0])
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!x_reg[0])
            begin
                x_next = x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_next = y_reg >> 1;
            end
            else if (!diff_xy[W])
            begin
                x_next = diff_xy[W:1];
            end
            else
            begin
                y_next = diff_yx[W:1];
            end
        end

        if (cmd.gcd_latch)
        begin
            g_next   = (x_reg | y_reg) << k_reg;
            rem_next = '0;
            quo_next = ma_reg;
            cnt_next = '0;
        end

        if (cmd.div_step)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shift_rem[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.mul)
        begin
            result_next.divisor     = DIVISOR_W'(g_reg);
            result_next.zero_divide = (g_reg == '0);
            result_next.multiple    = (g_reg == '0) ? '0 : MULTIPLE_W'(prod[PROD_W-2:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg   <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            k_reg   <= k_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        g_reg      <= g_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        result_reg <= result_next;
    end

    assign stat.gcd_zero = (x_reg == '0) || (y_reg == '0);
    assign stat.div_last = (cnt_reg == CNT_W'(W - 1));
    assign result        = result_reg;

`ifndef ASSERT_OFF
    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gcd_step |-> ((x_reg != '0) && (y_reg != '0)))
        else $error("gcd step with a zero operand");

    a_exact_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mul && (g_reg != '0)) |-> (rem_reg == '0))
        else $error("divisor does not divide first magnitude");

    a_zero_only_both: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |-> ((g_reg == '0) == ((ma_reg == '0) && (mb_reg == '0))))
        else $error("zero divisor with a nonzero operand");
`endif

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for gcd_lcm_unit (gcd and lcm of two signed operands).
// Runs a directed table and then random requests; each result is checked against table values or a local predictor.
// Depends on glu_pkg and gcd_lcm_unit.
module tb_top;

    import glu_pkg::*;

    localparam int DW = DATA_WIDTH_DEF;
    localparam longint unsigned OPND_MASK = (64'd1 << DW) - 64'd1;
    localparam int NUM_RANDOM = 750;
    localparam int NUM_PROBES = 20;
    localparam int SETTLE_CYCLES = 160;

    typedef struct packed {
        logic [OPERAND_W-1:0]  a;
        logic [OPERAND_W-1:0]  b;
        logic                  typed;
        logic [DIVISOR_W-1:0]  divisor;
        logic [MULTIPLE_W-1:0] multiple;
        logic                  zero_divide;
    } probe_row_t;

    probe_row_t probe_table [0:NUM_PROBES-1] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 63'h0, 1'b1},
        '{32'h0000_0005, 32'h0000_0000, 1'b1, 32'h0000_0005, 63'h0, 1'b0},
        '{32'h0000_0000, 32'hFFFF_FFF9, 1'b1, 32'h0000_0007, 63'h0, 1'b0},
        '{32'hFFFF_FFFB, 32'h0000_0000, 1'b1, 32'h0000_0005, 63'h0, 1'b0},
        '{32'h8000_0000, 32'h0000_0000, 1'b1, 32'h8000_0000, 63'h0, 1'b0},
        '{32'h0000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000, 63'h0, 1'b0},
        '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000, 63'h8000_0000, 1'b0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 63'h7FFF_FFFF, 1'b0},
        '{32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0000_0001, 63'h1, 1'b0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001, 63'h1, 1'b0},
        '{32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_0001, 63'h8000_0000, 1'b0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 63'h0, 1'b0},
        '{32'h0000_000C, 32'h0000_0012, 1'b0, 32'h0, 63'h0, 1'b0},
        '{32'hFFFF_FFF4, 32'h0000_0012, 1'b0, 32'h0, 63'h0, 1'b0},
        '{32'h0000_000C, 32'hFFFF_FFEE, 1'b0, 32'h0, 63'h0, 1'b0},
        '{32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 32'h0, 63'h0, 1'b0},
        '{32'h6D73_E55F, 32'h43A5_3F82, 1'b0, 32'h0, 63'h0, 1'b0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFED, 1'b0, 32'h0, 63'h0, 1'b0},
        '{32'h4000_0000, 32'hA000_0000, 1'b0, 32'h0, 63'h0, 1'b0},
        '{32'hFFFF_0000, 32'h0000_FFFF, 1'b0, 32'h0, 63'h0, 1'b0}
    };

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    glu_req_t  request = '0;
    logic      done;
    glu_rsp_t  result;

    glu_rsp_t  owed_results [$];
    glu_rsp_t  oldest_owed;
    int        mismatch_count = 0;
    bit        steady = 1'b0;

    gcd_lcm_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned operand_magnitude(logic [OPERAND_W-1:0] raw);
        longint unsigned v;
        v = 64'(raw) & OPND_MASK;
        if (v[DW-1])
        begin
            v = (64'd1 << DW) - v;
        end
        return v;
    endfunction

    function automatic glu_rsp_t gcd_lcm_of(glu_req_t r);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned x;
        longint unsigned y;
        longint unsigned rem;
        glu_rsp_t        res;
        ma = operand_magnitude(r.operand_a);
        mb = operand_magnitude(r.operand_b);
        x = ma;
        y = mb;
        while (y != 0)
        begin
            rem = x % y;
            x = y;
            y = rem;
        end
        res.divisor = x[DIVISOR_W-1:0];
        res.zero_divide = (x == 0);
        res.multiple = (x == 0) ? '0 : MULTIPLE_W'((ma * mb) / x);
        return res;
    endfunction

    function automatic logic [OPERAND_W-1:0] extreme_operand();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0001;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0000;
            default: return 32'h8000_0001;
        endcase
    endfunction

    function automatic glu_req_t random_operands();
        glu_req_t    r;
        int unsigned g;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        r.operand_a = $urandom;
        r.operand_b = $urandom;
        if (pick < 40)
        begin
            return r;
        end
        else if (pick < 60)
        begin
            g = $urandom_range(1, 65535);
            r.operand_a = g * $urandom_range(0, 32767);
            r.operand_b = g * $urandom_range(0, 32767);
        end
        else if (pick < 75)
        begin
            r.operand_a = $urandom_range(0, 1000);
            r.operand_b = $urandom_range(0, 1000);
        end
        else if (pick < 85)
        begin
            case ($urandom_range(0, 2))
                0: r.operand_a = '0;
                1: r.operand_b = '0;
                default:
                begin
                    r.operand_a = '0;
                    r.operand_b = '0;
                end
            endcase
        end
        else if (pick < 95)
        begin
            r.operand_a = extreme_operand();
            r.operand_b = extreme_operand();
        end
        else
        begin
            r.operand_a = 32'h1 << $urandom_range(0, 31);
            r.operand_b = 32'h1 << $urandom_range(0, 31);
        end
        if ($urandom_range(0, 1))
        begin
            r.operand_a = -r.operand_a;
        end
        if ($urandom_range(0, 1))
        begin
            r.operand_b = -r.operand_b;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 55)
        begin
            return 0;
        end
        else if (pick < 85)
        begin
            return $urandom_range(1, 4);
        end
        else if (pick < 97)
        begin
            return $urandom_range(5, 30);
        end
        return $urandom_range(31, 160);
    endfunction

    task automatic issue(input glu_req_t req, input glu_rsp_t due, input bit drain_first);
        int gap;
        gap = pick_gap();
        if (drain_first)
        begin
            start <= 1'b0;
            @(posedge clk);
            while (owed_results.size() != 0)
            begin
                @(posedge clk);
            end
        end
        else if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        owed_results.push_back(due);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (owed_results.size() == 0)
            begin
                $error("result with no request outstanding: divisor %0d multiple %0d",
                       result.divisor, result.multiple);
                mismatch_count++;
            end
            else
            begin
                oldest_owed = owed_results.pop_front();
                if (result.divisor !== oldest_owed.divisor)
                begin
                    $error("divisor expected %0d got %0d", oldest_owed.divisor, result.divisor);
                    mismatch_count++;
                end
                if (result.multiple !== oldest_owed.multiple)
                begin
                    $error("multiple expected %0d got %0d",
                           oldest_owed.multiple, result.multiple);
                    mismatch_count++;
                end
                if (result.zero_divide !== oldest_owed.zero_divide)
                begin
                    $error("zero_divide expected %0d got %0d",
                           oldest_owed.zero_divide, result.zero_divide);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        glu_req_t req;
        glu_rsp_t due;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_PROBES; i++)
        begin
            req.operand_a = probe_table[i].a;
            req.operand_b = probe_table[i].b;
            if (probe_table[i].typed)
            begin
                due.divisor = probe_table[i].divisor;
                due.multiple = probe_table[i].multiple;
                due.zero_divide = probe_table[i].zero_divide;
            end
            else
            begin
                due = gcd_lcm_of(req);
            end
            issue(req, due, 1'b0);
        end

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            steady = (i >= 300 && i < 360);
            req = random_operands();
            issue(req, gcd_lcm_of(req), (i == 400) || ($urandom_range(0, 99) == 0));
        end

        start <= 1'b0;
        @(posedge clk);
        while (owed_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
